/* sv/pst_pkg.sv */
// Shared types and constants for the Prim spanning tree engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package pst_pkg;

	// Default vertex capacity of the weight store
	localparam int MAX_VERTICES_DEF = 32;

	// Field widths
	localparam int VERTEX_W = 5;
	localparam int WEIGHT_W = 16;
	localparam int COST_W   = 17;
	localparam int COUNT_W  = 6;
	localparam int STATUS_W = 2;

	// Store code for a missing edge: top bit set, above any real weight
	localparam logic [COST_W-1:0] NO_EDGE = 17'h10000;

	// Item operations
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_START = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_EDGE         = 2'd0,
		STATUS_DISCONNECTED = 2'd1,
		STATUS_NO_EDGES     = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic                clear_wr;
		logic                load_wr1;
		logic                load_wr2;
		logic                start;
		logic                pass_begin;
		logic                scan;
		logic [VERTEX_W-1:0] scan_idx;
		logic                emit;
		status_t             emit_status;
		logic                emit_last;
		logic                advance;
	} pst_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic found;
		logic out_free;
	} pst_status_t;

endpackage

`default_nettype wire

/* sv/pst_if.sv */
// Valid/ready channel interfaces for input items and result words.
// Depends on pst_pkg for field widths.
`default_nettype none

interface pst_item_if;
	import pst_pkg::*;

	logic                valid;
	logic                ready;
	logic [0:0]          operation;
	logic [VERTEX_W-1:0] row_vertex;
	logic [VERTEX_W-1:0] col_vertex;
	logic [WEIGHT_W-1:0] edge_weight;
	logic                edge_present;
	logic [VERTEX_W-1:0] root_vertex;

	modport source (
		output valid, operation, row_vertex, col_vertex, edge_weight, edge_present,
			root_vertex,
		input  ready
	);
	modport sink (
		input  valid, operation, row_vertex, col_vertex, edge_weight, edge_present,
			root_vertex,
		output ready
	);
endinterface

interface pst_result_if;
	import pst_pkg::*;

	logic                valid;
	logic                ready;
	logic [VERTEX_W-1:0] parent_vertex;
	logic [VERTEX_W-1:0] child_vertex;
	logic [WEIGHT_W-1:0] tree_weight;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (
		output valid, parent_vertex, child_vertex, tree_weight, status, last,
		input  ready
	);
	modport sink (
		input  valid, parent_vertex, child_vertex, tree_weight, status, last,
		output ready
	);
endinterface

`default_nettype wire

/* sv/pst_ctrl.sv */
// Controller state machine: store clearing, edge loads, scan passes and emits.
// Depends on pst_pkg; drives the datapath through pst_cmd_t commands.
`default_nettype none

module pst_ctrl import pst_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_write,
	input  wire [COUNT_W-1:0]   cfg_data,
	input  wire                 in_valid,
	input  wire                 in_operation,
	input  wire [VERTEX_W-1:0]  in_root,
	output logic                in_ready,
	output pst_cmd_t            cmd,
	input  pst_status_t         stat
);

	localparam int ACTIVE_LIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
	localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(ACTIVE_LIMIT);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD2,
		ST_PASS,
		ST_DRAIN,
		ST_EMIT,
		ST_NO_TREE
	} state_t;

	state_t              state_q, state_n;
	logic [COUNT_W-1:0]  vertex_count_q;
	logic [COUNT_W-1:0]  n_q, n_n;
	logic [VERTEX_W-1:0] scan_q, scan_n;
	logic [COUNT_W-1:0]  edges_q, edges_n;
	logic [COUNT_W-1:0]  n_c;
	logic                bad_c;
	logic                accept;

	// Clamp the vertex count and check the root
	assign n_c    = (vertex_count_q > LIMIT) ? LIMIT : vertex_count_q;
	assign bad_c  = (n_c < COUNT_W'(2)) || (COUNT_W'(in_root) >= n_c);
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		cmd          = '0;
		cmd.scan_idx = scan_q;
		state_n      = state_q;
		n_n          = n_q;
		scan_n       = scan_q;
		edges_n      = edges_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_operation == OP_LOAD) begin
						cmd.load_wr1 = 1'b1;
						state_n      = ST_LOAD2;
					end else begin
						n_n = n_c;
						if (bad_c) begin
							state_n = ST_NO_TREE;
						end else begin
							cmd.start      = 1'b1;
							cmd.pass_begin = 1'b1;
							scan_n         = '0;
							edges_n        = '0;
							state_n        = ST_PASS;
						end
					end
				end
			end
			ST_LOAD2: begin
				cmd.load_wr2 = 1'b1;
				state_n      = ST_IDLE;
			end
			ST_PASS: begin
				cmd.scan = 1'b1;
				if (COUNT_W'(scan_q) == n_q - COUNT_W'(1)) begin
					state_n = ST_DRAIN;
				end else begin
					scan_n = scan_q + VERTEX_W'(1);
				end
			end
			ST_DRAIN: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (!stat.found) begin
						cmd.emit_status = STATUS_DISCONNECTED;
						cmd.emit_last   = 1'b1;
						state_n         = ST_IDLE;
					end else begin
						cmd.emit_status = STATUS_EDGE;
						if (edges_q == n_q - COUNT_W'(2)) begin
							cmd.emit_last = 1'b1;
							state_n       = ST_IDLE;
						end else begin
							cmd.advance    = 1'b1;
							cmd.pass_begin = 1'b1;
							edges_n        = edges_q + COUNT_W'(1);
							scan_n         = '0;
							state_n        = ST_PASS;
						end
					end
				end
			end
			ST_NO_TREE: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = STATUS_NO_EDGES;
					cmd.emit_last   = 1'b1;
					state_n         = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Hold state, counters and the vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			vertex_count_q <= '0;
			n_q            <= '0;
			scan_q         <= '0;
			edges_q        <= '0;
		end else begin
			state_q <= state_n;
			n_q     <= n_n;
			scan_q  <= scan_n;
			edges_q <= edges_n;
			if (cfg_write) begin
				vertex_count_q <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/pst_datapath.sv */
// Datapath: weight store, per-vertex cost and parent memories, tree marks,
// scan stage with running minimum, and the result register. Depends on pst_pkg.
`default_nettype none

module pst_datapath import pst_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pst_cmd_t            cmd,
	output pst_status_t         stat,
	input  wire [VERTEX_W-1:0]  row_vertex,
	input  wire [VERTEX_W-1:0]  col_vertex,
	input  wire [WEIGHT_W-1:0]  edge_weight,
	input  wire                 edge_present,
	input  wire [VERTEX_W-1:0]  root_vertex,
	pst_result_if.source        results
);

	localparam int ACTIVE_LIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
	localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
	localparam int AW           = $clog2(DEPTH);
	localparam int IW           = $clog2(ACTIVE_LIMIT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] addr_of(input logic [VERTEX_W-1:0] row,
		input logic [VERTEX_W-1:0] col);
		addr_of = AW'(row) * AW'(MAX_VERTICES) + AW'(col);
	endfunction

	function automatic logic in_range(input logic [VERTEX_W-1:0] v);
		in_range = int'(v) < MAX_VERTICES;
	endfunction

	// Weight store
	logic [COST_W-1:0]     ws_mem [DEPTH];
	logic [COST_W-1:0]     ws_rdata_q;
	logic                  ws_we;
	logic [AW-1:0]         ws_waddr;
	logic [COST_W-1:0]     ws_wdata;
	logic [AW-1:0]         ws_raddr;
	logic [AW-1:0]         clear_addr_q;

	// Second half of a symmetric load
	logic [AW-1:0]         swap_addr_q;
	logic [COST_W-1:0]     swap_val_q;
	logic                  swap_ok_q;
	logic [COST_W-1:0]     load_val;

	// Per-vertex cost and parent memories
	logic [COST_W-1:0]     cost_mem [ACTIVE_LIMIT];
	logic [VERTEX_W-1:0]   parent_mem [ACTIVE_LIMIT];
	logic [COST_W-1:0]     cost_rdata_q;
	logic [VERTEX_W-1:0]   parent_rdata_q;

	// Tree state
	logic [ACTIVE_LIMIT-1:0] in_tree_q;
	logic [VERTEX_W-1:0]   pick_q;
	logic                  init_q;

	// Scan stage
	logic                  valid_s1;
	logic [VERTEX_W-1:0]   idx_s1;
	logic                  in_t;
	logic                  take;
	logic [COST_W-1:0]     new_cost;
	logic [VERTEX_W-1:0]   new_parent;
	logic                  better;
	logic                  cost_we;

	// Running minimum
	logic [COST_W-1:0]     min_cost_q;
	logic [VERTEX_W-1:0]   min_idx_q;
	logic [VERTEX_W-1:0]   min_parent_q;

	// Result register
	logic                  out_valid_q;
	logic [VERTEX_W-1:0]   out_parent_q;
	logic [VERTEX_W-1:0]   out_child_q;
	logic [WEIGHT_W-1:0]   out_weight_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_last_q;

	assign load_val = edge_present ? {1'b0, edge_weight} : NO_EDGE;
	assign ws_raddr = addr_of(pick_q, cmd.scan_idx);

	// Select the store write: clearing sweep, first or second load entry
	always_comb begin
		ws_we    = 1'b0;
		ws_waddr = clear_addr_q;
		ws_wdata = NO_EDGE;
		if (cmd.clear_wr) begin
			ws_we = 1'b1;
		end else if (cmd.load_wr1) begin
			ws_we    = in_range(row_vertex) && in_range(col_vertex);
			ws_waddr = addr_of(row_vertex, col_vertex);
			ws_wdata = load_val;
		end else if (cmd.load_wr2) begin
			ws_we    = swap_ok_q;
			ws_waddr = swap_addr_q;
			ws_wdata = swap_val_q;
		end
	end

	// Relax one vertex against the new tree vertex and fold it into the minimum
	always_comb begin
		in_t       = in_tree_q[idx_s1[IW-1:0]];
		take       = init_q || (!in_t && (ws_rdata_q < cost_rdata_q));
		new_cost   = take ? ws_rdata_q : cost_rdata_q;
		new_parent = take ? pick_q : parent_rdata_q;
		better     = valid_s1 && !in_t && (new_cost < min_cost_q);
		cost_we    = valid_s1 && take;
	end

	// Weight store port
	always_ff @(posedge clk) begin
		if (ws_we) begin
			ws_mem[ws_waddr] <= ws_wdata;
		end
		if (cmd.scan) begin
			ws_rdata_q <= ws_mem[ws_raddr];
		end
	end

	// Cost and parent memory ports
	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[idx_s1[IW-1:0]]   <= ws_rdata_q;
			parent_mem[idx_s1[IW-1:0]] <= pick_q;
		end
		if (cmd.scan) begin
			cost_rdata_q   <= cost_mem[cmd.scan_idx[IW-1:0]];
			parent_rdata_q <= parent_mem[cmd.scan_idx[IW-1:0]];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
			in_tree_q    <= '0;
			init_q       <= 1'b0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear_wr) begin
				clear_addr_q <= clear_addr_q + AW'(1);
			end
			valid_s1 <= cmd.scan;
			if (cmd.start) begin
				in_tree_q <= ACTIVE_LIMIT'(1) << root_vertex;
				init_q    <= 1'b1;
			end else if (cmd.advance) begin
				in_tree_q[min_idx_q[IW-1:0]] <= 1'b1;
				init_q                       <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_wr1) begin
			swap_addr_q <= addr_of(col_vertex, row_vertex);
			swap_val_q  <= load_val;
			swap_ok_q   <= in_range(row_vertex) && in_range(col_vertex);
		end
		if (cmd.start) begin
			pick_q <= root_vertex;
		end else if (cmd.advance) begin
			pick_q <= min_idx_q;
		end
		idx_s1 <= cmd.scan_idx;
		if (cmd.pass_begin) begin
			min_cost_q <= NO_EDGE;
		end else if (better) begin
			min_cost_q   <= new_cost;
			min_idx_q    <= idx_s1;
			min_parent_q <= new_parent;
		end
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_last_q   <= cmd.emit_last;
			if (cmd.emit_status == STATUS_EDGE) begin
				out_parent_q <= min_parent_q;
				out_child_q  <= min_idx_q;
				out_weight_q <= min_cost_q[WEIGHT_W-1:0];
			end else begin
				out_parent_q <= '0;
				out_child_q  <= '0;
				out_weight_q <= '0;
			end
		end
	end

	// Status back to the controller
	assign stat.clear_last = (clear_addr_q == LAST_ADDR);
	assign stat.found      = !min_cost_q[COST_W-1];
	assign stat.out_free   = !out_valid_q || results.ready;

	// Drive the result channel
	assign results.valid         = out_valid_q;
	assign results.parent_vertex = out_parent_q;
	assign results.child_vertex  = out_child_q;
	assign results.tree_weight   = out_weight_q;
	assign results.status        = out_status_q;
	assign results.last          = out_last_q;

endmodule

`default_nettype wire

/* sv/prim_spanning_tree_engine.sv */
// Prim minimum spanning tree engine over an adjacency-matrix weight store.
// Load word: one store write per symmetric entry. Start word with n active
// vertices: one scan pass per tree edge (n store reads, drain, emit, the emit
// waiting while the output register is full) until a full tree is out or a pass finds
// no vertex to add and emits a disconnected result; a start with too few vertices or a
// bad root gives one no-edges result. Results leave through a one-word output register.
// Reset: arst_n clears control state, then a clearing pass over all MAX_VERTICES squared
// store entries (1024 by default) marks each of them as no edge before a word is taken.
`default_nettype none

module prim_spanning_tree_engine import pst_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_write,
	input  wire [COUNT_W-1:0]  cfg_data,
	pst_item_if.sink           items,
	pst_result_if.source       results
);

	pst_cmd_t    cmd;
	pst_status_t stat;
	logic        in_ready;

	assign items.ready = in_ready;

	// Sequence loads, clearing and tree build passes
	pst_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (items.valid),
		.in_operation (items.operation[0]),
		.in_root      (items.root_vertex),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	// Hold the graph and compute the tree
	pst_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.row_vertex   (items.row_vertex),
		.col_vertex   (items.col_vertex),
		.edge_weight  (items.edge_weight),
		.edge_present (items.edge_present),
		.root_vertex  (items.root_vertex),
		.results      (results)
	);

endmodule

`default_nettype wire
